/* rtl/lru_keyed_record_cache_macros.svh */
// Assertion macros shared by the cache RTL.
// Bodies compile away when SYNTHESIS is defined; no other dependencies.
`ifndef LRU_KEYED_RECORD_CACHE_MACROS_SVH
`define LRU_KEYED_RECORD_CACHE_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define LKRC_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// An implication checked in the same cycle.
`define LKRC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define LKRC_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define LKRC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/lkrc_pkg.sv */
// Shared types and constants for the keyed record cache.
// No dependencies; imported by lkrc_cell, lru_keyed_record_cache and the testbench.
package lkrc_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int KEY_WIDTH_DEF  = 32;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int         CAP_W     = 7;
	localparam logic [6:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LEFT  = 2'd1,
		CELL_RIGHT = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic     cmp_en;
		cell_op_t op;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

endpackage

/* rtl/lkrc_cell.sv */
// One entry of the recency-ordered cache chain: key, record and match flag.
// Depends on lkrc_pkg for the control struct.
module lkrc_cell #(
	parameter int KEY_W  = lkrc_pkg::KEY_WIDTH_DEF,
	parameter int DATA_W = lkrc_pkg::DATA_WIDTH_DEF,
	parameter int CNT_W  = 7,
	parameter int INDEX  = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lkrc_pkg::cell_ctrl_t    ctrl,
	input  logic [KEY_W-1:0]        cmp_key,
	input  logic [CNT_W-1:0]        count,
	input  logic [KEY_W-1:0]        left_key,
	input  logic [DATA_W-1:0]       left_data,
	input  logic [KEY_W-1:0]        right_key,
	input  logic [DATA_W-1:0]       right_data,
	output logic [KEY_W-1:0]        key_q,
	output logic [DATA_W-1:0]       data_q,
	output logic                    match_q
);
	import lkrc_pkg::*;

	logic occupied;

	// Entries are packed from position zero, so a cell holds a live record
	// exactly when its position is below the occupancy count.
	assign occupied = count > CNT_W'(INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			match_q <= occupied && (key_q == cmp_key);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_LEFT: begin
				key_q  <= left_key;
				data_q <= left_data;
			end
			CELL_RIGHT: begin
				key_q  <= right_key;
				data_q <= right_data;
			end
			CELL_HOLD: begin
				key_q  <= key_q;
				data_q <= data_q;
			end
			default: begin
				key_q  <= key_q;
				data_q <= data_q;
			end
		endcase
	end

endmodule

/* rtl/lru_keyed_record_cache.sv */
// Top level of the fully associative keyed record cache with LRU order.
// Depends on lkrc_pkg, lkrc_cell and lru_keyed_record_cache_macros.svh.
//
// Usage: a command beat (kind, key, record_data) is taken on a clock edge
// where start is high and busy is low. Kind selects lookup, write or delete.
// Exactly one result beat follows: done is high for one cycle with hit,
// read_data and evicted valid in that same cycle. The receiver cannot hold
// results off; the result registers are separate from the command side, so
// a new command may be taken in the very cycle that done is shown.
// The edge that takes a command also compares its key in every cell at
// once. In the update cycle that follows, busy is high; the edge that ends
// it moves the chain and loads the result, and done is high in the cycle
// after that. This order comes from the compare-then-shift pair of the cell
// chain, and no new command is taken during the update cycle.
// The capacity register is written through cfg_valid/cfg_data; cfg_ready is
// always high. Writes are meant to happen only while the cache is idle.
// Reset empties the cache (occupancy and high-water count cleared) and sets
// capacity to 64. No clearing pass is needed: stored keys and records are
// only ever read from cells below the occupancy count.
`include "lru_keyed_record_cache_macros.svh"

module lru_keyed_record_cache #(
	parameter int DEPTH      = lkrc_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH  = lkrc_pkg::KEY_WIDTH_DEF,
	parameter int DATA_WIDTH = lkrc_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [KEY_WIDTH-1:0]       key,
	input  logic [DATA_WIDTH-1:0]      record_data,
	output logic                       done,
	output logic                       hit,
	output logic [DATA_WIDTH-1:0]      read_data,
	output logic                       evicted,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lkrc_pkg::CAP_W-1:0] cfg_data
);
	import lkrc_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// The chain keeps records in recency order: position zero is the
	// youngest, and the live records fill positions 0..count-1 with no gaps.
	// A position therefore is the recency rank, and the oldest live record
	// sits at count-1. Writes push at position zero and shift the chain right
	// by one, up to the matched record or all of it on a miss; deletes close
	// the gap by shifting the older part left.

	state_t                  state_q, state_d;
	kind_t                   kind_q;
	logic [KEY_WIDTH-1:0]    key_q;
	logic [DATA_WIDTH-1:0]   din_q;
	logic [CAP_W-1:0]        cap_q;
	logic [CNT_W-1:0]        cnt_q;   // live records
	logic [CNT_W-1:0]        used_q;  // high-water mark of slots ever taken
	logic                    done_q, hit_q, evict_q;
	logic [DATA_WIDTH-1:0]   rdata_q;

	logic                    accept;
	logic                    exec;

	logic [KEY_WIDTH-1:0]    cell_key  [DEPTH];
	logic [DATA_WIDTH-1:0]   cell_data [DEPTH];
	logic [DEPTH-1:0]        match;
	cell_ctrl_t              ctrl      [DEPTH];

	logic [DEPTH-1:0]        match_pre;   // a match at this position or below
	logic [DEPTH-1:0]        match_suf;   // a match at this position or above
	logic                    any_match;
	logic [DATA_WIDTH-1:0]   match_data;

	logic [CMP_W-1:0]        eff_cap;
	logic                    has_free;
	logic                    can_grow;
	logic                    must_evict;

	logic                    res_hit, res_evict;
	logic [DATA_WIDTH-1:0]   res_data;
	logic                    ins_new, del_hit;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign exec      = (state_q == ST_EXEC);

	// Command FSM: idle until a beat is taken, then the update state, then idle again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Command payload, held for the update cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			key_q  <= key;
			din_q  <= record_data;
		end
	end

	// Cell chain. Cell zero loads the command's key and record when it
	// takes from the left; the last cell reloads itself when it takes from
	// the right.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_WIDTH-1:0]  l_key, r_key;
		logic [DATA_WIDTH-1:0] l_data, r_data;

		if (i == 0) begin : g_first
			assign l_key  = key_q;
			assign l_data = din_q;
		end else begin : g_mid_l
			assign l_key  = cell_key[i-1];
			assign l_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_key  = cell_key[i];
			assign r_data = cell_data[i];
		end else begin : g_mid_r
			assign r_key  = cell_key[i+1];
			assign r_data = cell_data[i+1];
		end

		lkrc_cell #(
			.KEY_W  (KEY_WIDTH),
			.DATA_W (DATA_WIDTH),
			.CNT_W  (CNT_W),
			.INDEX  (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[i]),
			.cmp_key    (key),
			.count      (cnt_q),
			.left_key   (l_key),
			.left_data  (l_data),
			.right_key  (r_key),
			.right_data (r_data),
			.key_q      (cell_key[i]),
			.data_q     (cell_data[i]),
			.match_q    (match[i])
		);
	end

	// Prefix and suffix OR of the one-hot match vector, in log2(DEPTH)
	// doubling steps.
	always_comb begin
		match_pre = match;
		match_suf = match;
		for (int d = 1; d < DEPTH; d = d * 2) begin
			match_pre = match_pre | (match_pre << d);
			match_suf = match_suf | (match_suf >> d);
		end
	end

	assign any_match = |match;

	always_comb begin
		match_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			match_data = match_data | (cell_data[i] & {DATA_WIDTH{match[i]}});
		end
	end

	// Capacity of zero behaves as one; anything above the depth saturates.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end

	// A freed slot exists whenever fewer records live than slots were taken.
	assign has_free   = cnt_q < used_q;
	assign can_grow   = CMP_W'(used_q) < eff_cap;
	assign must_evict = !has_free && !can_grow;

	// Per-cell moves and the result for the update cycle.
	always_comb begin
		res_hit   = 1'b0;
		res_data  = '0;
		res_evict = 1'b0;
		ins_new   = 1'b0;
		del_hit   = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].cmp_en = accept;
			ctrl[i].op     = CELL_HOLD;
		end
		if (exec) begin
			unique case (kind_q)
				KIND_LOOKUP: begin
					res_hit = any_match;
					if (any_match) begin
						res_data = match_data;
					end
				end
				KIND_WRITE: begin
					res_hit = any_match;
					if (any_match) begin
						// Update: everything up to the match moves right and
						// the record re-enters as the youngest.
						for (int i = 0; i < DEPTH; i++) begin
							ctrl[i].op = match_suf[i] ? CELL_LEFT : CELL_HOLD;
						end
					end else begin
						// Insert: the whole chain moves right. On eviction
						// the oldest record slides past the count and is gone.
						for (int i = 0; i < DEPTH; i++) begin
							ctrl[i].op = CELL_LEFT;
						end
						res_evict = must_evict;
						ins_new   = !must_evict;
					end
				end
				KIND_DELETE: begin
					res_hit = any_match;
					if (any_match) begin
						del_hit = 1'b1;
						for (int i = 0; i < DEPTH; i++) begin
							ctrl[i].op = match_pre[i] ? CELL_RIGHT : CELL_HOLD;
						end
					end
				end
				default: begin
					res_hit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			cnt_q   <= '0;
			used_q  <= '0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			evict_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (ins_new) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
				if (!has_free) begin
					used_q <= CNT_W'(used_q + 1'b1);
				end
			end else if (del_hit) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
			done_q  <= exec;
			hit_q   <= res_hit;
			evict_q <= res_evict;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= res_data;
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign read_data = rdata_q;
	assign evicted   = evict_q;

	`LKRC_ASSERT_HOLDS(a_cnt_le_used, clk, arst_n, cnt_q <= used_q, "live count above high-water mark")
	`LKRC_ASSERT_HOLDS(a_used_le_depth, clk, arst_n, CMP_W'(used_q) <= CMP_W'(DEPTH), "high-water mark above depth")
	`LKRC_ASSERT_HOLDS(a_match_onehot, clk, arst_n, $onehot0(match), "key matched in more than one cell")
	`LKRC_ASSERT_IMPLIES(a_done_after_exec, clk, arst_n, done, $past(state_q == ST_EXEC), "result without an update cycle")
	`LKRC_ASSERT_IMPLIES(a_evict_on_miss, clk, arst_n, evicted, done && !hit && cnt_q == used_q, "eviction outside a full write miss")

endmodule

/* test/tb.sv */
// Self-checking testbench for lru_keyed_record_cache: lookups, writes and deletes
// are checked against a cycle-free cache predictor under several capacities.
// Depends on lkrc_pkg and the lru_keyed_record_cache RTL only.
module tb;
	import lkrc_pkg::*;

	localparam int KEY_W  = KEY_WIDTH_DEF;
	localparam int DATA_W = DATA_WIDTH_DEF;
	localparam int SLOTS  = DEPTH_DEF;

	// The command port is two bits wide, but the package only names three kinds.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int KEY_POOL_SIZE   = 80;
	localparam int ITEMS_PER_PHASE = 215;
	localparam int NUM_PHASES      = 7;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_data;
		logic              evicted;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        kind = KIND_LOOKUP;
	logic [KEY_W-1:0]  key = '0;
	logic [DATA_W-1:0] record_data = '0;
	logic              done;
	logic              hit;
	logic [DATA_W-1:0] read_data;
	logic              evicted;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data = '0;

	lru_keyed_record_cache i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key(key),
		.record_data(record_data),
		.done(done),
		.hit(hit),
		.read_data(read_data),
		.evicted(evicted),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Commands waiting to be driven, and results owed by commands already taken.
	cmd_t    pending_cmds[$];
	result_t expected_results[$];

	// Keys are drawn mostly from a small pool so that hits, updates, deletes
	// and evictions all happen often; the span of the pool follows capacity.
	logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

	int          idle_pct = 0;
	bit          beat_taken = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned cmds_taken = 0;
	int unsigned results_seen = 0;
	int unsigned hits_seen = 0;
	int unsigned evictions_seen = 0;
	int unsigned cap_writes = 0;

	// Shadow copy of the cache contents. The slot a new key lands in is not
	// visible at the ports, but tracking it exactly keeps eviction order right.
	logic [KEY_W-1:0]  shadow_key  [SLOTS];
	logic [DATA_W-1:0] shadow_data [SLOTS];
	bit                shadow_valid[SLOTS];
	int unsigned       shadow_age  [SLOTS];
	int unsigned       slots_taken;
	logic [CAP_W-1:0]  shadow_capacity;

	// Applies one command to the shadow cache and returns the result it owes.
	// Age 0 is the youngest entry; valid entries hold ages 0 to n-1.
	function automatic result_t cache_apply(cmd_t c);
		result_t     r;
		int          match;
		int          slot;
		int unsigned usable;
		int unsigned old_age;
		int unsigned oldest;
		r = '0;
		match = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (match < 0 && shadow_valid[i] && shadow_key[i] == c.key)
				match = i;
		end
		case (c.kind)
			KIND_LOOKUP: begin
				// A lookup never touches the recency order.
				if (match >= 0) begin
					r.hit = 1'b1;
					r.read_data = shadow_data[match];
				end
			end
			KIND_WRITE: begin
				if (match >= 0) begin
					// Update in place: only entries younger than this one age.
					r.hit = 1'b1;
					shadow_data[match] = c.data;
					old_age = shadow_age[match];
					for (int i = 0; i < SLOTS; i++) begin
						if (shadow_valid[i] && i != match && shadow_age[i] < old_age)
							shadow_age[i]++;
					end
					shadow_age[match] = 0;
				end else begin
					// Freed slots first, then a fresh slot below the capacity,
					// and only then the oldest entry is pushed out.
					slot = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (slot < 0 && i < slots_taken && !shadow_valid[i])
							slot = i;
					end
					if (shadow_capacity == '0)
						usable = 1;
					else if (32'(shadow_capacity) > SLOTS)
						usable = SLOTS;
					else
						usable = 32'(shadow_capacity);
					if (slot < 0 && slots_taken < usable) begin
						slot = slots_taken;
						slots_taken++;
					end
					if (slot < 0) begin
						oldest = 0;
						for (int i = 0; i < SLOTS; i++) begin
							if (shadow_valid[i] && (slot < 0 || shadow_age[i] >= oldest)) begin
								slot = i;
								oldest = shadow_age[i];
							end
						end
						shadow_valid[slot] = 1'b0;
						r.evicted = 1'b1;
					end
					shadow_key[slot] = c.key;
					shadow_data[slot] = c.data;
					shadow_valid[slot] = 1'b1;
					for (int i = 0; i < SLOTS; i++) begin
						if (shadow_valid[i] && i != slot)
							shadow_age[i]++;
					end
					shadow_age[slot] = 0;
				end
			end
			KIND_DELETE: begin
				// Entries older than the deleted one move up by one.
				if (match >= 0) begin
					r.hit = 1'b1;
					old_age = shadow_age[match];
					shadow_valid[match] = 1'b0;
					shadow_age[match] = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (shadow_valid[i] && shadow_age[i] > old_age)
							shadow_age[i]--;
					end
				end
			end
			default: begin
				// The unused kind changes nothing and reports all zeros.
			end
		endcase
		return r;
	endfunction

	function automatic cmd_t random_cmd(int unsigned span);
		cmd_t        c;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			c.kind = KIND_LOOKUP;
		else if (pick < 75)
			c.kind = KIND_WRITE;
		else if (pick < 94)
			c.kind = KIND_DELETE;
		else
			c.kind = KIND_UNUSED;
		if ($urandom_range(9) == 0)
			c.key = $urandom;
		else
			c.key = key_pool[$urandom_range(span - 1)];
		c.data = $urandom;
		return c;
	endfunction

	task automatic push_cmd(logic [1:0] k, logic [KEY_W-1:0] kv, logic [DATA_W-1:0] dv);
		cmd_t c;
		c.kind = k;
		c.key = kv;
		c.data = dv;
		pending_cmds.push_back(c);
	endtask

	task automatic flag_mismatch(string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Blocks until every queued command has been taken and answered, then
	// lets the cache settle before anything else happens.
	task automatic wait_drained();
		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Capacity writes are only issued while the cache is idle.
	task automatic write_capacity(logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	// Driver: a new command goes out at the falling edge once the previous
	// beat was taken; start stays up, unchanged, while busy holds it off.
	always @(negedge clk) begin : drive_cmds
		cmd_t next_cmd;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_cmd = pending_cmds.pop_front();
				start <= 1'b1;
				kind <= next_cmd.kind;
				key <= next_cmd.key;
				record_data <= next_cmd.data;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: at each rising edge the result beat is checked first, then a
	// capacity write or a newly taken command updates the shadow cache. A
	// result can never belong to a command taken on the same edge.
	always @(posedge clk) begin : check_results
		result_t want;
		cmd_t    taken;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Timed out after %0d cycles with %0d results owed",
					cycle_count, expected_results.size());
				$display("RESULT: ERROR");
				$finish;
			end else begin
				if (done) begin
					results_seen++;
					if (hit)
						hits_seen++;
					if (evicted)
						evictions_seen++;
					if (expected_results.size() == 0) begin
						flag_mismatch("result beat with no command outstanding");
					end else begin
						want = expected_results.pop_front();
						if (hit !== want.hit)
							flag_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
						if (read_data !== want.read_data)
							flag_mismatch($sformatf("read_data %h, expected %h",
								read_data, want.read_data));
						if (evicted !== want.evicted)
							flag_mismatch($sformatf("evicted %b, expected %b",
								evicted, want.evicted));
					end
				end
				if (cfg_valid && cfg_ready)
					shadow_capacity = cfg_data;
				beat_taken = start && !busy;
				if (beat_taken) begin
					taken.kind = kind;
					taken.key = key;
					taken.data = record_data;
					expected_results.push_back(cache_apply(taken));
					cmds_taken++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [CAP_W-1:0] phase_cap;
		int unsigned      usable;
		int unsigned      span;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_age[i] = 0;
			shadow_key[i] = '0;
			shadow_data[i] = '0;
		end
		slots_taken = 0;
		shadow_capacity = CAP_RESET;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening: key and data extremes, every kind, update of an
		// existing key, delete hit and miss, the unused kind, and reuse of a
		// freed slot by a new key.
		push_cmd(KIND_LOOKUP, '0, '1);
		push_cmd(KIND_WRITE, '0, '0);
		push_cmd(KIND_WRITE, '1, '1);
		push_cmd(KIND_LOOKUP, '0, '1);
		push_cmd(KIND_LOOKUP, '1, '0);
		push_cmd(KIND_LOOKUP, 32'h0000_0001, '0);
		push_cmd(KIND_WRITE, '0, 32'hA5A5_5A5A);
		push_cmd(KIND_LOOKUP, '0, '0);
		push_cmd(KIND_UNUSED, '0, '1);
		push_cmd(KIND_UNUSED, 32'h1234_5678, 32'h8765_4321);
		push_cmd(KIND_DELETE, '1, '0);
		push_cmd(KIND_DELETE, '1, '0);
		push_cmd(KIND_LOOKUP, '1, '0);
		push_cmd(KIND_DELETE, 32'h8000_0000, '0);
		push_cmd(KIND_WRITE, 32'h8000_0000, 32'h7FFF_FFFF);
		push_cmd(KIND_WRITE, 32'h7FFF_FFFF, 32'h8000_0000);
		push_cmd(KIND_LOOKUP, 32'h8000_0000, '0);
		push_cmd(KIND_LOOKUP, 32'h7FFF_FFFF, '0);
		push_cmd(KIND_WRITE, 32'h8000_0000, 32'hFFFF_0000);
		push_cmd(KIND_LOOKUP, 32'h8000_0000, '0);

		// Each phase pairs a capacity with an idling pattern. The first runs
		// at the reset capacity and fills most slots, so the drop to five
		// that follows lands below the number of slots already taken. Zero
		// must act as one and 127 must saturate at the full depth.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: phase_cap = CAP_RESET;
				1: phase_cap = 7'd5;
				2: phase_cap = 7'd0;
				3: phase_cap = 7'd127;
				4: phase_cap = 7'd1;
				5: phase_cap = 7'd64;
				default: phase_cap = CAP_W'($urandom_range(40, 2));
			endcase
			if (phase != 0) begin
				wait_drained();
				write_capacity(phase_cap);
			end
			case (phase % 4)
				1: idle_pct = 84;
				3: idle_pct = 29;
				default: idle_pct = 0;
			endcase
			usable = (phase_cap == '0) ? 1 :
				(32'(phase_cap) > SLOTS) ? SLOTS : 32'(phase_cap);
			span = (usable + 6 > KEY_POOL_SIZE) ? KEY_POOL_SIZE : usable + 6;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				pending_cmds.push_back(random_cmd(span));
		end

		wait_drained();
		if (expected_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("Ran %0d commands over %0d capacity settings (%0d writes of the register).",
			cmds_taken, NUM_PHASES, cap_writes);
		$display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches.",
			results_seen, hits_seen, evictions_seen, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
